>>> sv/lrl_pkg.sv
// Shared types, constants and the sequencer microcode for the line run lookup block.
package lrl_pkg;

    localparam int OFFSET_BITS     = 24;
    localparam int LINE_BITS       = 16;
    localparam int INDEX_BITS      = 8;
    localparam int COUNT_BITS      = 9;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int STEP_BITS       = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Word index of the entry count register within the register window.
    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic [STEP_BITS-1:0] STEP_WAIT   = 2'd0;
    localparam logic [STEP_BITS-1:0] STEP_ISSUE  = 2'd1;
    localparam logic [STEP_BITS-1:0] STEP_PROBE  = 2'd2;
    localparam logic [STEP_BITS-1:0] STEP_FINISH = 2'd3;

    typedef struct packed {
        logic                   kind;
        logic [INDEX_BITS-1:0]  entry_index;
        logic [OFFSET_BITS-1:0] entry_start;
        logic [LINE_BITS-1:0]   entry_line;
        logic [OFFSET_BITS-1:0] query_offset;
    } lrl_item_t;

    typedef struct packed {
        logic                 found;
        logic [LINE_BITS-1:0] line;
    } lrl_result_t;

    typedef enum logic [1:0] {
        COND_QUERY    = 2'd0,
        COND_MORE     = 2'd1,
        COND_NEXT     = 2'd2,
        COND_OUT_FREE = 2'd3
    } lrl_cond_t;

    typedef struct packed {
        logic                 in_rdy;
        logic                 ld_query;
        logic                 probe;
        logic                 emit;
        lrl_cond_t            cond;
        logic [STEP_BITS-1:0] jmp;
        logic [STEP_BITS-1:0] nxt;
    } lrl_ctl_t;

    typedef struct packed {
        logic query_acc;
        logic more;
        logic next_more;
        logic out_free;
    } lrl_status_t;

    function automatic lrl_ctl_t lrl_rom(input logic [STEP_BITS-1:0] step);
        lrl_ctl_t w;
        w = '0;
        unique case (step)
            STEP_WAIT:
            begin
                w.in_rdy   = 1'b1;
                w.ld_query = 1'b1;
                w.cond     = COND_QUERY;
                w.jmp      = STEP_ISSUE;
                w.nxt      = STEP_WAIT;
            end
            STEP_ISSUE:
            begin
                w.cond = COND_MORE;
                w.jmp  = STEP_PROBE;
                w.nxt  = STEP_FINISH;
            end
            STEP_PROBE:
            begin
                w.probe = 1'b1;
                w.cond  = COND_NEXT;
                w.jmp   = STEP_PROBE;
                w.nxt   = STEP_FINISH;
            end
            STEP_FINISH:
            begin
                w.emit = 1'b1;
                w.cond = COND_OUT_FREE;
                w.jmp  = STEP_WAIT;
                w.nxt  = STEP_FINISH;
            end
            default:
            begin
                w.cond = COND_QUERY;
                w.jmp  = STEP_WAIT;
                w.nxt  = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/lrl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lrl_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module lrl_seq
    import lrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lrl_status_t status,
    output lrl_ctl_t    ctl
);

    logic [STEP_BITS-1:0] pc_reg;
    logic [STEP_BITS-1:0] pc_next;
    logic                 taken;

    assign ctl = lrl_rom(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            COND_QUERY:    taken = status.query_acc;
            COND_MORE:     taken = status.more;
            COND_NEXT:     taken = status.next_more;
            COND_OUT_FREE: taken = status.out_free;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? ctl.jmp : ctl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> sv/line_run_lookup_core.sv
// Top level of the line run lookup block: register port, table and search datapath.
// Writes may follow each other in every cycle while no query is being searched.
// A query searches with P probes, one table read each, where P is at most floor(log2(n)) + 1
// for n searched records and 0 for n = 0; the result is registered, and no new item is taken
// while a query is searched or while its result waits to enter the result register.
// Reset clears entry_count and control state, not the table.
module line_run_lookup_core
    import lrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  lrl_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output lrl_result_t result
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int WIDX = (AW > INDEX_BITS) ? AW : INDEX_BITS;
    localparam int RW   = OFFSET_BITS + LINE_BITS;

    lrl_ctl_t    ctl;
    lrl_status_t status;

    logic [COUNT_BITS-1:0]  entry_count_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [CW-1:0]          low_reg;
    logic [CW-1:0]          hx_reg;
    logic [CW-1:0]          mid_reg;
    logic                   found_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic                   result_valid_reg;
    lrl_result_t            result_reg;

    logic [CW-1:0]          low_next;
    logic [CW-1:0]          hx_next;
    logic [CW:0]            mid_sum;
    logic [CW-1:0]          mid_next;
    logic [CW-1:0]          count_lim;
    logic                   accept;
    logic                   hit;
    logic                   ram_we;
    logic [WIDX-1:0]        widx;
    logic [RW-1:0]          rdata;
    logic [OFFSET_BITS-1:0] rd_start;
    logic [LINE_BITS-1:0]   rd_line;

    lrl_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    // Register port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(entry_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata[COUNT_BITS-1:0];
        end
    end

    // Table writes.
    assign item_ready = ctl.in_rdy;
    assign accept     = item_valid && item_ready;
    assign widx       = WIDX'(item.entry_index);
    assign ram_we     = accept && (item.kind == KIND_WRITE)
                        && (32'(item.entry_index) < 32'(TABLE_DEPTH));

    lrl_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx[AW-1:0]),
        .wdata ({item.entry_start, item.entry_line}),
        .raddr (mid_next[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_start = rdata[RW-1:LINE_BITS];
    assign rd_line  = rdata[LINE_BITS-1:0];

    // Search datapath; hx_reg is one past the upper bound of the search range.
    assign count_lim = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                               : CW'(entry_count_reg);
    assign hit       = (rd_start <= offset_reg);

    always_comb
    begin
        low_next = low_reg;
        hx_next  = hx_reg;
        if (ctl.probe)
        begin
            if (hit)
            begin
                low_next = mid_reg + CW'(1);
            end
            else
            begin
                hx_next = mid_reg;
            end
        end
        mid_sum  = {1'b0, low_next} + {1'b0, hx_next} - (CW + 1)'(1);
        mid_next = mid_sum[CW:1];
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        if (ctl.ld_query && accept)
        begin
            offset_reg <= item.query_offset;
            low_reg    <= '0;
            hx_reg     <= count_lim;
            found_reg  <= 1'b0;
            line_reg   <= '0;
        end
        else
        begin
            low_reg <= low_next;
            hx_reg  <= hx_next;
            if (ctl.probe && hit)
            begin
                found_reg <= 1'b1;
                line_reg  <= rd_line;
            end
        end
    end

    // Result register.
    assign status.query_acc = accept && (item.kind == KIND_QUERY);
    assign status.more      = (low_reg < hx_reg);
    assign status.next_more = (low_next < hx_next);
    assign status.out_free  = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.emit && status.out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit && status.out_free)
        begin
            result_reg.found <= found_reg;
            result_reg.line  <= line_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> sv/lrl_checker.sv
// Port-level assertions for the line run lookup block and their binding.
module lrl_checker
    import lrl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input lrl_item_t   item,
    input logic        result_valid,
    input logic        result_ready,
    input lrl_result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("Stalled result transfer changed or dropped.");

    a_miss_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.line == '0)
        else $error("A result without a match carries a nonzero line.");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.kind == KIND_WRITE) && !result_valid
        |=> !result_valid)
        else $error("A write transfer produced a result.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.kind == KIND_QUERY) |=> !item_ready)
        else $error("A new item was taken right after a query.");

endmodule

bind line_run_lookup_core lrl_checker u_lrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> tb/line_run_lookup_core_test.sv
// Self-checking bench for line_run_lookup_core: directed and random table loads and floor searches.
`timescale 1ns / 100ps

module line_run_lookup_core_test;
    import lrl_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_TARGET  = 700;
    localparam int ROW_COUNT    = 23;
    localparam logic [2:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef struct packed {
        logic                   do_cfg;
        logic [31:0]            cfg_data;
        logic                   kind;
        logic [INDEX_BITS-1:0]  idx;
        logic [OFFSET_BITS-1:0] start;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] offset;
        logic                   typed;
        logic                   exp_found;
        logic [LINE_BITS-1:0]   exp_line;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_ready;
    lrl_item_t   item;
    logic        result_valid;
    logic        result_ready = 1'b0;
    lrl_result_t result;

    logic [OFFSET_BITS-1:0] shadow_start [TABLE_DEPTH_DEF];
    logic [LINE_BITS-1:0]   shadow_line [TABLE_DEPTH_DEF];
    logic [COUNT_BITS-1:0]  shadow_count;
    lrl_result_t            lines_due [$];
    int                     mismatch_count = 0;
    int                     items_sent = 0;
    int                     cycle_count = 0;
    bit                     no_idle = 1'b0;

    directed_row_t directed_rows [ROW_COUNT] = '{
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'h000000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'hFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h00, 24'h000000, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h01, 24'd10,     16'h0001, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h02, 24'd20,     16'h0002, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'hFF, 24'hFFFFFF, 16'hABCD, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'hFFFF_FE03, KIND_QUERY, 8'h00, 24'h0, 16'h0, 24'h000000, 1'b1, 1'b1, 16'hFFFF},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd9,      1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd10,     1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd19,     1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h03, 24'd5,      16'h0007, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'd4, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd6,      1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd4,      1'b0, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h00, 24'd100,    16'h1234, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'd1, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd50,     1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd100,    1'b1, 1'b1, 16'h1234},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'd99,     1'b1, 1'b0, 16'h0000},
        '{1'b1, 32'd0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'hFFFFFF, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_WRITE, 8'h00, 24'hFFFFFF, 16'h8001, 24'h000000, 1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'd1, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'hFFFFFF, 1'b1, 1'b1, 16'h8001},
        '{1'b0, 32'h0, KIND_QUERY, 8'h00, 24'h000000, 16'h0000, 24'hFFFFFE, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0, KIND_QUERY, 8'hFF, 24'hFFFFFF, 16'hFFFF, 24'h000000, 1'b1, 1'b0, 16'h0000}
    };

    line_run_lookup_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 40)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    function automatic lrl_result_t lookup_line(input logic [OFFSET_BITS-1:0] offset);
        int          lo;
        int          hi;
        int          mid;
        int          hit;
        lrl_result_t r;
        lo  = 0;
        hi  = (int'(shadow_count) > TABLE_DEPTH_DEF ? TABLE_DEPTH_DEF : int'(shadow_count)) - 1;
        hit = -1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_start[mid] <= offset)
            begin
                hit = mid;
                lo  = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        r.found = (hit >= 0);
        r.line  = (hit >= 0) ? shadow_line[hit] : '0;
        return r;
    endfunction

    task automatic send_item(input lrl_item_t it, input bit typed, input lrl_result_t typed_res);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        if (it.kind == KIND_QUERY)
        begin
            lines_due.push_back(typed ? typed_res : lookup_line(it.query_offset));
        end
        else
        begin
            shadow_start[it.entry_index] = it.entry_start;
            shadow_line[it.entry_index]  = it.entry_line;
        end
        items_sent++;
    endtask

    task automatic set_entry_count(input logic [31:0] data);
        item_valid <= 1'b0;
        while (lines_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        shadow_count = data[COUNT_BITS-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== {{(32 - COUNT_BITS){1'b0}}, shadow_count})
        begin
            flag_mismatch($sformatf("entry_count read back %0h, wrote %0h", prdata, shadow_count));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        lrl_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (lines_due.size() == 0)
            begin
                flag_mismatch($sformatf("result transfer with none pending: found %0b line %0h",
                                        result.found, result.line));
            end
            else
            begin
                want = lines_due.pop_front();
                if (result.found !== want.found)
                begin
                    flag_mismatch($sformatf("found %0b, predicted %0b", result.found, want.found));
                end
                if (result.line !== want.line)
                begin
                    flag_mismatch($sformatf("line %0h, predicted %0h", result.line, want.line));
                end
            end
        end
        result_ready <= no_idle || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        lrl_item_t   it;
        lrl_result_t typed_res;
        lrl_result_t no_res;
        logic [31:0] cfg_word;
        int          phase;
        int          cnt;
        int          eff;
        int          nq;
        int          pick;
        int unsigned cur;
        bit          dense;
        bit          scrambled;

        no_res       = '0;
        shadow_count = '0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (directed_rows[r].do_cfg)
            begin
                set_entry_count(directed_rows[r].cfg_data);
            end
            it.kind         = directed_rows[r].kind;
            it.entry_index  = directed_rows[r].idx;
            it.entry_start  = directed_rows[r].start;
            it.entry_line   = directed_rows[r].line;
            it.query_offset = directed_rows[r].offset;
            typed_res.found = directed_rows[r].exp_found;
            typed_res.line  = directed_rows[r].exp_line;
            send_item(it, directed_rows[r].typed, typed_res);
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0: cnt = 511;
                1: cnt = 256;
                2: cnt = 0;
                3: cnt = 1;
                4: cnt = 2;
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        cnt = $urandom_range(1, 16);
                    else if (pick < 85)
                        cnt = $urandom_range(17, 64);
                    else if (pick < 92)
                        cnt = 0;
                    else
                        cnt = $urandom_range(256, 511);
                end
            endcase
            cfg_word = cnt;
            if (phase == 0 || $urandom_range(3) == 0)
            begin
                cfg_word = ($urandom & 32'hFFFF_FE00) | cnt;
            end
            set_entry_count(cfg_word);
            eff = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cnt;

            // Load the searched records, normally in ascending start order.
            dense     = $urandom_range(1);
            scrambled = ($urandom_range(9) == 0);
            cur       = $urandom_range(0, dense ? 64 : 4096);
            for (int i = 0; i < eff; i++)
            begin
                no_idle         = (items_sent >= 250 && items_sent < 400);
                it.kind         = KIND_WRITE;
                it.entry_index  = INDEX_BITS'(i);
                it.entry_start  = OFFSET_BITS'(scrambled ? $urandom : cur);
                it.entry_line   = LINE_BITS'($urandom);
                it.query_offset = OFFSET_BITS'($urandom);
                send_item(it, 1'b0, no_res);
                cur = cur + (dense ? $urandom_range(0, 4) : $urandom_range(0, 24'hFFFFFF / eff));
                if (cur > 24'hFFFFFF)
                    cur = 24'hFFFFFF;
            end

            nq = $urandom_range(8, 24);
            for (int q = 0; q < nq; q++)
            begin
                no_idle = (items_sent >= 250 && items_sent < 400);
                if ($urandom_range(9) == 0)
                begin
                    it.kind         = KIND_WRITE;
                    it.entry_index  = INDEX_BITS'($urandom);
                    it.entry_start  = OFFSET_BITS'($urandom);
                    it.entry_line   = LINE_BITS'($urandom);
                    it.query_offset = OFFSET_BITS'($urandom);
                    send_item(it, 1'b0, no_res);
                end
                it.kind        = KIND_QUERY;
                it.entry_index = INDEX_BITS'($urandom);
                it.entry_start = OFFSET_BITS'($urandom);
                it.entry_line  = LINE_BITS'($urandom);
                pick           = $urandom_range(99);
                if (eff > 0 && pick < 40)
                    it.query_offset = shadow_start[$urandom_range(0, eff - 1)];
                else if (eff > 0 && pick < 60)
                    it.query_offset = shadow_start[$urandom_range(0, eff - 1)] - 1'b1;
                else if (pick < 80)
                    it.query_offset = OFFSET_BITS'($urandom);
                else if (pick < 90)
                    it.query_offset = '0;
                else
                    it.query_offset = '1;
                send_item(it, 1'b0, no_res);
            end
            phase++;
        end

        item_valid <= 1'b0;
        while (lines_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
